// ----- src/rfp_pkg.sv -----
`timescale 1ns / 1ps

package rfp_pkg;

	localparam logic [7:0]  SYNC_BYTE     = 8'h52;
	localparam logic [7:0]  TYPE_A_BYTE   = 8'h41;
	localparam logic [7:0]  TYPE_B_BYTE   = 8'h42;
	localparam logic [7:0]  TYPE_C_BYTE   = 8'h43;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_XOROUT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
	localparam logic [6:0]  LEN_A         = 7'd16;
	localparam logic [6:0]  LEN_B         = 7'd32;
	localparam logic [6:0]  LEN_C         = 7'd48;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_TYPE = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_A = 2'd0,
		KIND_B = 2'd1,
		KIND_C = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]  frame_kind;
		logic        check_status;
		logic [7:0]  proto_version;
		logic [7:0]  frame_counter;
		logic [15:0] range_raw;
		logic [15:0] echo_strength;
		logic        gain_flag;
		logic        no_track_flag;
		logic        failure_flag;
	} rfp_result_t;

	// Reflected CRC-16-CCITT, one byte per call.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [6:0] frame_len(input logic [1:0] kind);
		logic [6:0] len;
		case (kind)
			KIND_B:  len = LEN_B;
			KIND_C:  len = LEN_C;
			default: len = LEN_A;
		endcase
		return len;
	endfunction

endpackage

// ----- src/ranging_frame_parser_crc16_unit.sv -----
`timescale 1ns / 1ps

// Serial frame parser for a ranging sensor. Bytes enter one per request on the
// input channel; the parser hunts for the 'R' sync byte, takes 'A', 'B' or 'C'
// as the frame type (16, 32 or 48 bytes in all) and checks a CRC-16/X-25 over
// every byte but the little-endian two-byte trailer. On the last byte of a
// frame one result request leaves: the frame type, the check status and, for a
// good type A frame, the decoded payload (zeros otherwise). A byte takes one
// cycle through the input register and the bytewise CRC update, so one byte is
// accepted every cycle while input does not stall; results leave from an
// output register behind the input register, and input stalls only while
// the output register holds an untaken result and a further byte is waiting.

module ranging_frame_parser_crc16_unit import rfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  frame_kind,
	output logic        check_status,
	output logic [7:0]  proto_version,
	output logic [7:0]  frame_counter,
	output logic [15:0] range_raw,
	output logic [15:0] echo_strength,
	output logic        gain_flag,
	output logic        no_track_flag,
	output logic        failure_flag
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        adv;
	logic        out_free;
	logic        res_valid;
	rfp_result_t res;
	logic        out_valid_q;
	rfp_result_t res_q;

	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
		end
	end

	rfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.data_byte (data_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_kind    = res_q.frame_kind;
	assign check_status  = res_q.check_status;
	assign proto_version = res_q.proto_version;
	assign frame_counter = res_q.frame_counter;
	assign range_raw     = res_q.range_raw;
	assign echo_strength = res_q.echo_strength;
	assign gain_flag     = res_q.gain_flag;
	assign no_track_flag = res_q.no_track_flag;
	assign failure_flag  = res_q.failure_flag;

endmodule

// ----- src/rfp_parser.sv -----
`timescale 1ns / 1ps

module rfp_parser import rfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  data_byte,
	output logic        res_valid,
	output rfp_result_t res
);

	phase_t      phase_q, phase_d;
	logic [1:0]  kind_q, kind_d;
	logic [5:0]  idx_q, idx_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  version_q, version_d;
	logic [7:0]  counter_q, counter_d;
	logic [15:0] range_q, range_d;
	logic [15:0] strength_q, strength_d;
	logic [2:0]  flags_q, flags_d;
	logic [7:0]  trailer_q, trailer_d;

	logic [6:0]  len;
	logic [6:0]  idx_ext;
	logic [15:0] crc_next;
	logic [15:0] received;
	logic        good;
	logic        typea;

	assign len      = frame_len(kind_q);
	assign idx_ext  = {1'b0, idx_q} + 7'd2;
	assign crc_next = crc_feed(crc_q, data_byte);
	assign received = {data_byte, trailer_q};
	assign good     = ((crc_q ^ CRC_XOROUT) == received);
	assign typea    = (kind_q != KIND_B) && (kind_q != KIND_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			kind_q     <= KIND_A;
			idx_q      <= '0;
			crc_q      <= CRC_INIT;
			version_q  <= '0;
			counter_q  <= '0;
			range_q    <= '0;
			strength_q <= '0;
			flags_q    <= '0;
			trailer_q  <= '0;
		end else if (en) begin
			phase_q    <= phase_d;
			kind_q     <= kind_d;
			idx_q      <= idx_d;
			crc_q      <= crc_d;
			version_q  <= version_d;
			counter_q  <= counter_d;
			range_q    <= range_d;
			strength_q <= strength_d;
			flags_q    <= flags_d;
			trailer_q  <= trailer_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		idx_d      = idx_q;
		crc_d      = crc_q;
		version_d  = version_q;
		counter_d  = counter_q;
		range_d    = range_q;
		strength_d = strength_q;
		flags_d    = flags_q;
		trailer_d  = trailer_q;
		res_valid  = 1'b0;
		res        = '0;
		unique case (phase_q)
			PH_TYPE: begin
				if (data_byte == TYPE_A_BYTE || data_byte == TYPE_B_BYTE ||
				    data_byte == TYPE_C_BYTE) begin
					kind_d  = 2'(data_byte - TYPE_A_BYTE);
					crc_d   = crc_next;
					idx_d   = 6'd2;
					phase_d = PH_BODY;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				if (idx_ext < len) begin
					crc_d = crc_next;
					case (idx_q)
						6'd2:    version_d = data_byte;
						6'd3:    counter_d = data_byte;
						6'd4:    range_d[15:8] = data_byte;
						6'd5:    range_d[7:0] = data_byte;
						6'd10:   strength_d[15:8] = data_byte;
						6'd11:   strength_d[7:0] = data_byte;
						6'd13:   flags_d = {data_byte[3], data_byte[1], data_byte[0]};
						default: ;
					endcase
					idx_d = idx_q + 6'd1;
				end else if (idx_ext == len) begin
					trailer_d = data_byte;
					idx_d     = idx_q + 6'd1;
				end else begin
					res_valid        = 1'b1;
					res.frame_kind   = typea ? KIND_A : kind_q;
					res.check_status = !good;
					if (good && typea) begin
						res.proto_version = version_q;
						res.frame_counter = counter_q;
						res.range_raw     = range_q;
						res.echo_strength = strength_q;
						res.gain_flag     = flags_q[0];
						res.no_track_flag = flags_q[1];
						res.failure_flag  = flags_q[2];
					end
					phase_d = PH_HUNT;
					idx_d   = '0;
					crc_d   = CRC_INIT;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (data_byte == SYNC_BYTE) begin
					crc_d   = crc_feed(CRC_INIT, data_byte);
					idx_d   = 6'd1;
					phase_d = PH_TYPE;
				end
			end
		endcase
	end

	a_res_only_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> phase_q == PH_BODY)
		else $error("result raised outside the frame body");

	a_restart_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(en && res_valid) |=> (phase_q == PH_HUNT && crc_q == CRC_INIT && idx_q == 6'd0))
		else $error("parser not restarted after a frame");

	a_bad_crc_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.check_status) |-> (res.range_raw == 16'd0 &&
		res.echo_strength == 16'd0 && res.proto_version == 8'd0))
		else $error("payload shown for a frame with a bad check");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> {1'b0, idx_q} < LEN_C)
		else $error("byte index beyond the longest frame");

endmodule
